// ===== sv/vcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// vcsd_pkg
// Shared types and constants of the CAN signal decoder.
// ----------------------------------------------------------------------------
package vcsd_pkg;

  // Standard identifiers of the frames that are decoded.
  localparam logic [10:0] ID_TEMPS   = 11'h3FF;
  localparam logic [10:0] ID_SPEED   = 11'h320;
  localparam logic [10:0] ID_ODO     = 11'h520;
  localparam logic [10:0] ID_SOC     = 11'h355;
  localparam logic [10:0] ID_PACK    = 11'h356;
  localparam logic [10:0] ID_MINV    = 11'h373;
  localparam logic [10:0] ID_CURRENT = 11'h521;
  localparam logic [10:0] ID_POWER   = 11'h526;
  localparam logic [10:0] ID_CHARGE  = 11'h527;
  localparam logic [10:0] ID_ENERGY  = 11'h528;

  // Signal codes on the result channel.
  localparam logic [3:0] SIG_INV_TEMP   = 4'd0;
  localparam logic [3:0] SIG_MOTOR_TEMP = 4'd1;
  localparam logic [3:0] SIG_SPEED      = 4'd2;
  localparam logic [3:0] SIG_ODOMETER   = 4'd3;
  localparam logic [3:0] SIG_TRIP_DIST  = 4'd4;
  localparam logic [3:0] SIG_SOC        = 4'd5;
  localparam logic [3:0] SIG_PACK_VOLT  = 4'd6;
  localparam logic [3:0] SIG_PACK_TEMP  = 4'd7;
  localparam logic [3:0] SIG_MIN_VOLT   = 4'd8;
  localparam logic [3:0] SIG_CURRENT    = 4'd9;
  localparam logic [3:0] SIG_POWER      = 4'd10;
  localparam logic [3:0] SIG_TRIP_CHG   = 4'd11;
  localparam logic [3:0] SIG_ENERGY     = 4'd12;

  localparam int ODO_W = 20;
  localparam int ACC_W = 31;

  // Division of a 16-bit value by 100 as multiply by a reciprocal.
  localparam logic [17:0] DIV100_MAGIC = 18'd167773;
  localparam int          DIV100_SHIFT = 24;

  typedef enum logic [3:0] {
    K_TEMPS, K_SPEED, K_ODO, K_SOC, K_PACK,
    K_MINV, K_CURRENT, K_POWER, K_CHARGE, K_ENERGY
  } kind_t;

  typedef enum logic {PH_FIRST, PH_SECOND} phase_t;

  // Classified frame waiting for the back end.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] val_a;
    logic [15:0] val_b;
  } frame_t;

  typedef struct packed {
    logic [3:0]         code;
    logic signed [31:0] value;
    logic               last;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic second;
  } back_stat_t;

endpackage

// ===== sv/vcsd_fifo.sv =====
// ----------------------------------------------------------------------------
// vcsd_fifo
// Small register queue with a fall-through head, used between stages.
// ----------------------------------------------------------------------------
module vcsd_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output item_t rdata,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/vcsd_front.sv =====
// ----------------------------------------------------------------------------
// vcsd_front
// Classifies an incoming frame by identifier and extracts its raw fields.
// ----------------------------------------------------------------------------
module vcsd_front (
  input  logic            push,
  output logic            full,
  input  logic [10:0]     in_frame_id,
  input  logic [7:0]      in_byte0,
  input  logic [7:0]      in_byte1,
  input  logic [7:0]      in_byte2,
  input  logic [7:0]      in_byte3,
  input  logic [7:0]      in_byte4,
  input  logic [7:0]      in_byte5,
  input  logic [7:0]      in_byte6,
  input  logic [7:0]      in_byte7,
  input  logic            q_full,
  output logic            q_push,
  output vcsd_pkg::frame_t q_item
);
  import vcsd_pkg::*;

  logic        hit;
  logic [15:0] raw16;
  logic [33:0] prod;
  logic [9:0]  quot;
  logic [31:0] word;

  assign raw16 = {in_byte1, in_byte0};
  assign prod  = 34'(raw16) * 34'(DIV100_MAGIC);
  assign quot  = prod[DIV100_SHIFT +: 10];
  assign word  = {in_byte5, in_byte4, in_byte3, in_byte2};

  always_comb begin
    hit          = 1'b1;
    q_item.kind  = K_TEMPS;
    q_item.val_a = '0;
    q_item.val_b = '0;
    unique case (in_frame_id)
      ID_TEMPS: begin
        q_item.kind  = K_TEMPS;
        q_item.val_a = {24'd0, in_byte0};
        q_item.val_b = {8'd0, in_byte1};
      end
      ID_SPEED: begin
        q_item.kind  = K_SPEED;
        q_item.val_a = {17'd0, in_byte4, in_byte3[7:1]};
      end
      ID_ODO: begin
        q_item.kind  = K_ODO;
        q_item.val_a = {12'd0, in_byte7[3:0], in_byte6, in_byte5};
      end
      ID_SOC: begin
        q_item.kind  = K_SOC;
        q_item.val_a = {16'd0, raw16};
      end
      ID_PACK: begin
        q_item.kind  = K_PACK;
        q_item.val_a = {22'd0, quot};
        q_item.val_b = {in_byte5, in_byte4};
      end
      ID_MINV: begin
        q_item.kind  = K_MINV;
        q_item.val_a = {22'd0, quot};
      end
      ID_CURRENT: begin
        q_item.kind  = K_CURRENT;
        q_item.val_a = word;
      end
      ID_POWER: begin
        q_item.kind  = K_POWER;
        q_item.val_a = word;
      end
      ID_CHARGE: begin
        q_item.kind  = K_CHARGE;
        q_item.val_a = word;
      end
      ID_ENERGY: begin
        q_item.kind  = K_ENERGY;
        q_item.val_a = word;
      end
      default: hit = 1'b0;
    endcase
  end

  // Unknown identifiers are accepted and dropped here.
  assign full   = q_full;
  assign q_push = push && !q_full && hit;

endmodule

// ===== sv/vcsd_back.sv =====
// ----------------------------------------------------------------------------
// vcsd_back
// Emits the results of one classified frame and keeps the trip accumulators.
// ----------------------------------------------------------------------------
module vcsd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vcsd_pkg::frame_t     head,
  input  logic                 head_valid,
  output logic                 head_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output vcsd_pkg::result_t    res,
  output vcsd_pkg::back_stat_t stat
);
  import vcsd_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [ODO_W-1:0]   prev_odo_r, prev_odo_nxt;
  logic [ACC_W-1:0]   trip_dist_r, trip_dist_nxt;
  logic [31:0]        prev_chg_r, prev_chg_nxt;
  logic [ACC_W-1:0]   trip_chg_r, trip_chg_nxt;
  logic [31:0]        inc_r, inc_nxt;

  logic               go;
  logic [ODO_W-1:0]   odo_new;
  logic               odo_fwd;
  logic               chg_fwd;
  logic [32:0]        chg_diff;
  logic [ACC_W-1:0]   acc_sel;
  logic [32:0]        acc_sum;
  logic [ACC_W-1:0]   acc_new;

  assign go       = head_valid && !res_full;
  assign odo_new  = head.val_a[ODO_W-1:0];
  assign odo_fwd  = (odo_new > prev_odo_r) && (prev_odo_r != '0);
  assign chg_fwd  = ($signed(head.val_a) > $signed(prev_chg_r)) && (prev_chg_r != '0);
  assign chg_diff = {head.val_a[31], head.val_a} - {prev_chg_r[31], prev_chg_r};

  // One saturating adder serves both trip accumulators.
  assign acc_sel = (head.kind == K_ODO) ? trip_dist_r : trip_chg_r;
  assign acc_sum = {2'b00, acc_sel} + {1'b0, inc_r};
  assign acc_new = (acc_sum[32:31] != 2'b00) ? '1 : acc_sum[ACC_W-1:0];

  always_comb begin
    phase_nxt     = phase_r;
    prev_odo_nxt  = prev_odo_r;
    trip_dist_nxt = trip_dist_r;
    prev_chg_nxt  = prev_chg_r;
    trip_chg_nxt  = trip_chg_r;
    inc_nxt       = inc_r;
    head_pop      = 1'b0;
    res_push      = 1'b0;
    res.code      = SIG_INV_TEMP;
    res.value     = '0;
    res.last      = 1'b0;
    if (go) begin
      unique case (phase_r)
        PH_FIRST: begin
          unique case (head.kind)
            K_TEMPS: begin
              res_push  = 1'b1;
              res.code  = SIG_INV_TEMP;
              res.value = head.val_a;
              phase_nxt = PH_SECOND;
            end
            K_SPEED: begin
              res_push  = 1'b1;
              res.code  = SIG_SPEED;
              res.value = head.val_a;
              res.last  = 1'b1;
              head_pop  = 1'b1;
            end
            K_ODO: begin
              res_push     = 1'b1;
              res.code     = SIG_ODOMETER;
              res.value    = head.val_a;
              prev_odo_nxt = odo_new;
              inc_nxt      = odo_fwd ? 32'(odo_new - prev_odo_r) : '0;
              phase_nxt    = PH_SECOND;
            end
            K_SOC: begin
              res_push  = 1'b1;
              res.code  = SIG_SOC;
              res.value = head.val_a;
              res.last  = 1'b1;
              head_pop  = 1'b1;
            end
            K_PACK: begin
              res_push  = 1'b1;
              res.code  = SIG_PACK_VOLT;
              res.value = head.val_a;
              phase_nxt = PH_SECOND;
            end
            K_MINV: begin
              res_push  = 1'b1;
              res.code  = SIG_MIN_VOLT;
              res.value = head.val_a;
              res.last  = 1'b1;
              head_pop  = 1'b1;
            end
            K_CURRENT: begin
              res_push  = 1'b1;
              res.code  = SIG_CURRENT;
              res.value = head.val_a;
              res.last  = 1'b1;
              head_pop  = 1'b1;
            end
            K_POWER: begin
              res_push  = 1'b1;
              res.code  = SIG_POWER;
              res.value = head.val_a;
              res.last  = 1'b1;
              head_pop  = 1'b1;
            end
            K_CHARGE: begin
              // The counter is stored now; its result follows in the second phase.
              prev_chg_nxt = head.val_a;
              inc_nxt      = chg_fwd ? chg_diff[31:0] : '0;
              phase_nxt    = PH_SECOND;
            end
            K_ENERGY: begin
              res_push  = 1'b1;
              res.code  = SIG_ENERGY;
              res.value = head.val_a;
              res.last  = 1'b1;
              head_pop  = 1'b1;
            end
            default: head_pop = 1'b1;
          endcase
        end
        PH_SECOND: begin
          res_push  = 1'b1;
          res.last  = 1'b1;
          head_pop  = 1'b1;
          phase_nxt = PH_FIRST;
          unique case (head.kind)
            K_TEMPS: begin
              res.code  = SIG_MOTOR_TEMP;
              res.value = {16'd0, head.val_b};
            end
            K_PACK: begin
              res.code  = SIG_PACK_TEMP;
              res.value = {16'd0, head.val_b};
            end
            K_ODO: begin
              res.code      = SIG_TRIP_DIST;
              res.value     = {1'b0, acc_new};
              trip_dist_nxt = acc_new;
            end
            K_CHARGE: begin
              res.code     = SIG_TRIP_CHG;
              res.value    = {1'b0, acc_new};
              trip_chg_nxt = acc_new;
            end
            default: res_push = 1'b0;
          endcase
        end
        default: phase_nxt = PH_FIRST;
      endcase
    end
  end

  assign stat.push   = res_push;
  assign stat.pop    = head_pop;
  assign stat.second = (phase_r == PH_SECOND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      prev_odo_r  <= '0;
      trip_dist_r <= '0;
      prev_chg_r  <= '0;
      trip_chg_r  <= '0;
    end else begin
      phase_r     <= phase_nxt;
      prev_odo_r  <= prev_odo_nxt;
      trip_dist_r <= trip_dist_nxt;
      prev_chg_r  <= prev_chg_nxt;
      trip_chg_r  <= trip_chg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inc_r <= inc_nxt;
  end

endmodule

// ===== sv/vehicle_can_signal_decoder.sv =====
// ----------------------------------------------------------------------------
// vehicle_can_signal_decoder
// Decodes received CAN frames into code/value signal items.
// ----------------------------------------------------------------------------
// Path: a frame is classified by the front and queued; the back end then
// writes its result items into the output queue.
// Throughput: the back end emits at most one result item per cycle while the
// output queue is not full; frames with two results and charge-counter
// frames, whose accumulator update uses a second phase, also take that phase.
// Reset: synchronous, active low; queues empty, odometer, charge counter and
// both trip accumulators cleared to zero.
// ----------------------------------------------------------------------------
module vehicle_can_signal_decoder #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [10:0]        in_frame_id,
  input  logic [7:0]         in_byte0,
  input  logic [7:0]         in_byte1,
  input  logic [7:0]         in_byte2,
  input  logic [7:0]         in_byte3,
  input  logic [7:0]         in_byte4,
  input  logic [7:0]         in_byte5,
  input  logic [7:0]         in_byte6,
  input  logic [7:0]         in_byte7,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         out_signal_code,
  output logic signed [31:0] out_signal_value,
  output logic               out_last_of_frame
);
  import vcsd_pkg::*;

  // Front to back: classified frames. Unknown identifiers never enter.
  logic       mid_push, mid_full, mid_pop, mid_empty;
  frame_t     mid_in, mid_head;

  // Back to output: one result item per entry.
  logic       res_push, res_full;
  result_t    res_in, res_head;
  back_stat_t stat;

  // The front classifies the frame and precomputes the divided voltages,
  // so the back end only selects fields and runs the accumulators.
  vcsd_front u_front (
    .push        (push),
    .full        (full),
    .in_frame_id (in_frame_id),
    .in_byte0    (in_byte0),
    .in_byte1    (in_byte1),
    .in_byte2    (in_byte2),
    .in_byte3    (in_byte3),
    .in_byte4    (in_byte4),
    .in_byte5    (in_byte5),
    .in_byte6    (in_byte6),
    .in_byte7    (in_byte7),
    .q_full      (mid_full),
    .q_push      (mid_push),
    .q_item      (mid_in)
  );

  vcsd_fifo #(
    .item_t (frame_t),
    .DEPTH  (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_head),
    .empty (mid_empty)
  );

  // The back end holds a frame at the head of the queue while it emits
  // its results; it stalls only when the output queue is full.
  vcsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (mid_head),
    .head_valid (!mid_empty),
    .head_pop   (mid_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in),
    .stat       (stat)
  );

  // The output queue parts the back end from the consumer, so a waiting
  // result does not block the next frame.
  vcsd_fifo #(
    .item_t (result_t),
    .DEPTH  (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign out_signal_code   = res_head.code;
  assign out_signal_value  = res_head.value;
  assign out_last_of_frame = res_head.last;

  // The back end never writes a result into a full output queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.push |-> !res_full)
    else $error("result written while output queue full");

  // A frame in its second phase stays at the head of the queue.
  a_second_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    stat.second |-> !mid_empty)
    else $error("second phase without a frame");

  // Two-result frames are not released in their first phase.
  a_pop_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.pop && !stat.second) |->
      (mid_head.kind != K_TEMPS && mid_head.kind != K_PACK &&
       mid_head.kind != K_ODO && mid_head.kind != K_CHARGE))
    else $error("two-phase frame popped early");

  // After reset the output queue is empty and the input is not full.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CAN signal decoder. A short table of directed
// frames covers every identifier, the field extremes, unknown identifiers and
// the odometer and charge-counter corner cases. It is followed by random
// frames biased toward meaningful odometer and counter sequences, and by an
// odometer sweep of large forward steps that grows trip distance quickly.
// Every result item is checked, in order, against the values written in the
// directed rows or against an in-bench model of the decoder.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vcsd_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_FRAMES = 300;    // per random phase, two phases
  localparam int SWEEP_FRAMES  = 124;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 10;

  // One received frame; data[i] is data byte i.
  typedef struct packed {
    logic [10:0]     id;
    logic [7:0][7:0] data;
  } can_frame_t;

  // One row of stimulus. Where typed is set, the expected signals are the
  // ones written in the row; otherwise the decoder model supplies them.
  typedef struct {
    can_frame_t  frame;
    bit          typed;
    int          n_res;
    logic [3:0]  c0;
    logic [31:0] v0;
    logic [3:0]  c1;
    logic [31:0] v1;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic [10:0]        in_frame_id;
  logic [7:0]         in_byte0;
  logic [7:0]         in_byte1;
  logic [7:0]         in_byte2;
  logic [7:0]         in_byte3;
  logic [7:0]         in_byte4;
  logic [7:0]         in_byte5;
  logic [7:0]         in_byte6;
  logic [7:0]         in_byte7;
  logic               empty;
  logic               pop;
  logic [3:0]         out_signal_code;
  logic signed [31:0] out_signal_value;
  logic               out_last_of_frame;

  vehicle_can_signal_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_frame_id      (in_frame_id),
    .in_byte0         (in_byte0),
    .in_byte1         (in_byte1),
    .in_byte2         (in_byte2),
    .in_byte3         (in_byte3),
    .in_byte4         (in_byte4),
    .in_byte5         (in_byte5),
    .in_byte6         (in_byte6),
    .in_byte7         (in_byte7),
    .empty            (empty),
    .pop              (pop),
    .out_signal_code  (out_signal_code),
    .out_signal_value (out_signal_value),
    .out_last_of_frame(out_last_of_frame)
  );

  // Decoded signals still owed by the block, oldest first.
  result_t pending_signals[$];
  stim_row_t dir_rows[$];

  // Model state: last readings and the two trip accumulators.
  logic [19:0]        odo_prev;
  logic [30:0]        trip_dist;
  logic signed [31:0] charge_prev;
  logic [30:0]        trip_chg;

  // Stimulus-side memory of the last odometer and counter that were sent,
  // so that random frames can form plausible forward sequences.
  logic [19:0] gen_odo;
  logic [31:0] gen_chg;

  int burst_left;
  int frames_sent;
  int signals_checked;
  int mismatches;
  int cycles;

  // --------------------------------------------------------------------------
  // Clock.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run is cut off if it ever takes far longer than the slowest correct
  // run could (all frames double-result, every result stalled to the limit).
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d signals still pending", cycles,
             pending_signals.size());
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Decoder model.
  // --------------------------------------------------------------------------

  // Adds an increase into a 31-bit trip accumulator, saturating at its top.
  function automatic logic [30:0] sat_acc(input logic [30:0] acc, input logic [32:0] inc);
    logic [33:0] sum;
    sum = {3'b000, acc} + {1'b0, inc};
    if (sum > 34'h07FFF_FFFF) begin
      return '1;
    end else begin
      return sum[30:0];
    end
  endfunction

  // Works out the signals one frame produces and updates the model state.
  function automatic void decode_frame(input can_frame_t f, output result_t res[2],
                                       output int n);
    logic [31:0]        word;
    logic [19:0]        odo;
    logic signed [32:0] diff;
    word = {f.data[5], f.data[4], f.data[3], f.data[2]};
    n = 0;
    res[0] = '0;
    res[1] = '0;
    case (f.id)
      ID_TEMPS: begin
        res[0] = '{code: SIG_INV_TEMP, value: {24'b0, f.data[0]}, last: 1'b0};
        res[1] = '{code: SIG_MOTOR_TEMP, value: {24'b0, f.data[1]}, last: 1'b1};
        n = 2;
      end
      ID_SPEED: begin
        // byte4 lands on bits 14:7 and byte3 >> 1 on bits 6:0; no carries.
        res[0] = '{code: SIG_SPEED, value: {17'b0, f.data[4], f.data[3][7:1]},
                   last: 1'b1};
        n = 1;
      end
      ID_ODO: begin
        odo = {f.data[7][3:0], f.data[6], f.data[5]};
        if (odo > odo_prev && odo_prev != 20'd0) begin
          trip_dist = sat_acc(trip_dist, 33'(odo - odo_prev));
        end
        odo_prev = odo;
        res[0] = '{code: SIG_ODOMETER, value: {12'b0, odo}, last: 1'b0};
        res[1] = '{code: SIG_TRIP_DIST, value: {1'b0, trip_dist}, last: 1'b1};
        n = 2;
      end
      ID_SOC: begin
        res[0] = '{code: SIG_SOC, value: {16'b0, f.data[1], f.data[0]}, last: 1'b1};
        n = 1;
      end
      ID_PACK: begin
        res[0] = '{code: SIG_PACK_VOLT, value: {16'b0, f.data[1], f.data[0]} / 32'd100,
                   last: 1'b0};
        res[1] = '{code: SIG_PACK_TEMP, value: {16'b0, f.data[5], f.data[4]}, last: 1'b1};
        n = 2;
      end
      ID_MINV: begin
        res[0] = '{code: SIG_MIN_VOLT, value: {16'b0, f.data[1], f.data[0]} / 32'd100,
                   last: 1'b1};
        n = 1;
      end
      ID_CURRENT: begin
        res[0] = '{code: SIG_CURRENT, value: word, last: 1'b1};
        n = 1;
      end
      ID_POWER: begin
        res[0] = '{code: SIG_POWER, value: word, last: 1'b1};
        n = 1;
      end
      ID_CHARGE: begin
        // Signed compare; the 33-bit difference cannot overflow.
        if ($signed(word) > charge_prev && charge_prev != 32'sd0) begin
          diff = $signed(word) - charge_prev;
          trip_chg = sat_acc(trip_chg, 33'(diff));
        end
        charge_prev = $signed(word);
        res[0] = '{code: SIG_TRIP_CHG, value: {1'b0, trip_chg}, last: 1'b1};
        n = 1;
      end
      ID_ENERGY: begin
        res[0] = '{code: SIG_ENERGY, value: word, last: 1'b1};
        n = 1;
      end
      default: begin
        // Unknown identifier: nothing comes out and the state stays.
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic add_row(input logic [10:0] id, input logic [63:0] bytes, input bit typed,
                         input int n, input logic [3:0] c0, input logic [31:0] v0,
                         input logic [3:0] c1, input logic [31:0] v1);
    stim_row_t r;
    r.frame.id   = id;
    r.frame.data = bytes;
    r.typed      = typed;
    r.n_res      = n;
    r.c0         = c0;
    r.v0         = v0;
    r.c1         = c1;
    r.v1         = v1;
    dir_rows.push_back(r);
  endtask

  // Random frame. Most carry a known identifier; odometer and counter frames
  // mostly step forward from the last value sent, with equal, zero, backward
  // and wild readings mixed in.
  function automatic can_frame_t make_random_frame();
    can_frame_t  f;
    logic [19:0] odo;
    logic [31:0] cnt;
    int          pick;
    f.data = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 12) begin
      f.id = 11'($urandom_range(0, 2047));
    end else begin
      case ($urandom_range(0, 9))
        0: f.id = ID_TEMPS;
        1: f.id = ID_SPEED;
        2: f.id = ID_ODO;
        3: f.id = ID_SOC;
        4: f.id = ID_PACK;
        5: f.id = ID_MINV;
        6: f.id = ID_CURRENT;
        7: f.id = ID_POWER;
        8: f.id = ID_CHARGE;
        default: f.id = ID_ENERGY;
      endcase
    end
    pick = $urandom_range(0, 99);
    if (f.id == ID_ODO) begin
      if (pick < 55) begin
        odo = gen_odo + 20'($urandom_range(1, 300));
      end else if (pick < 65) begin
        odo = gen_odo + 20'($urandom_range(1, 20'hFFFFF));
      end else if (pick < 75) begin
        odo = gen_odo;
      end else if (pick < 83) begin
        odo = 20'd0;
      end else if (pick < 90) begin
        odo = gen_odo - 20'($urandom_range(1, 50));
      end else begin
        odo = 20'($urandom);
      end
      // The upper nibble of byte 7 keeps its random bits.
      f.data[7][3:0] = odo[19:16];
      f.data[6]      = odo[15:8];
      f.data[5]      = odo[7:0];
      gen_odo        = odo;
    end
    if (f.id == ID_CHARGE) begin
      if (pick < 50) begin
        cnt = gen_chg + 32'($urandom_range(1, 5000));
      end else if (pick < 60) begin
        cnt = $urandom;
      end else if (pick < 70) begin
        cnt = gen_chg;
      end else if (pick < 78) begin
        cnt = 32'd0;
      end else if (pick < 88) begin
        cnt = gen_chg - 32'($urandom_range(1, 5000));
      end else begin
        cnt = gen_chg + $urandom;
      end
      {f.data[5], f.data[4], f.data[3], f.data[2]} = cnt;
      gen_chg = cnt;
    end
    return f;
  endfunction

  // Puts one frame on the input ports and holds it until the block takes it.
  task automatic send_frame(input can_frame_t f);
    push        <= 1'b1;
    in_frame_id <= f.id;
    in_byte0    <= f.data[0];
    in_byte1    <= f.data[1];
    in_byte2    <= f.data[2];
    in_byte3    <= f.data[3];
    in_byte4    <= f.data[4];
    in_byte5    <= f.data[5];
    in_byte6    <= f.data[6];
    in_byte7    <= f.data[7];
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Sender pacing: bursts of back-to-back frames, then a random gap.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // Holds the sender off until every owed signal has come out.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending_signals.size() != 0) @(posedge clk);
  endtask

  // Sends one row and records what it must produce. The model runs for every
  // row, typed or not, so that its state follows the block.
  task automatic run_row(input stim_row_t r);
    result_t res[2];
    int      n;
    send_frame(r.frame);
    frames_sent++;
    decode_frame(r.frame, res, n);
    if (r.typed) begin
      if (r.n_res > 0) begin
        pending_signals.push_back('{code: r.c0, value: r.v0, last: (r.n_res == 1)});
      end
      if (r.n_res > 1) begin
        pending_signals.push_back('{code: r.c1, value: r.v1, last: 1'b1});
      end
    end else begin
      for (int i = 0; i < n; i++) pending_signals.push_back(res[i]);
    end
    pace();
  endtask

  // --------------------------------------------------------------------------
  // Result side: checks every item taken and stalls on a shifting pattern of
  // its own (free running, light random stalls, or longer stalls).
  // --------------------------------------------------------------------------
  initial begin
    result_t want;
    int      rx_mode;
    int      mode_left;
    int      stall_left;
    pop        <= 1'b0;
    rx_mode    = 0;
    mode_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        signals_checked++;
        if (pending_signals.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected result item: code %0d value %0d last %0d",
                     out_signal_code, out_signal_value, out_last_of_frame);
          end
        end else begin
          want = pending_signals.pop_front();
          if (want.code !== out_signal_code || want.value !== out_signal_value ||
              want.last !== out_last_of_frame) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch: expected code %0d value %0d last %0d, got code %0d value %0d last %0d",
                       want.code, want.value, want.last,
                       out_signal_code, out_signal_value, out_last_of_frame);
            end
          end
        end
      end
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        case (rx_mode)
          1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
          2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 8);
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t r;
    rst_n       <= 1'b0;
    push        <= 1'b0;
    in_frame_id <= '0;
    in_byte0    <= '0;
    in_byte1    <= '0;
    in_byte2    <= '0;
    in_byte3    <= '0;
    in_byte4    <= '0;
    in_byte5    <= '0;
    in_byte6    <= '0;
    in_byte7    <= '0;
    odo_prev        = '0;
    trip_dist       = '0;
    charge_prev     = '0;
    trip_chg        = '0;
    gen_odo         = '0;
    gen_chg         = '0;
    burst_left      = 0;
    frames_sent     = 0;
    signals_checked = 0;
    mismatches      = 0;

    // Directed table. Bytes are written byte7 first, byte0 last.
    // Temperatures at both extremes.
    add_row(ID_TEMPS, 64'h0000_0000_0000_00FF, 1, 2, SIG_INV_TEMP, 255, SIG_MOTOR_TEMP, 0);
    add_row(ID_TEMPS, 64'hFFFF_FFFF_FFFF_FF00, 1, 2, SIG_INV_TEMP, 0, SIG_MOTOR_TEMP, 255);
    // Speed: top value, and a low bit of byte3 that is shifted out.
    add_row(ID_SPEED, 64'h0000_00FF_FF00_0000, 1, 1, SIG_SPEED, 32767, '0, '0);
    add_row(ID_SPEED, 64'hFFFF_FF00_01FF_FFFF, 1, 1, SIG_SPEED, 0, '0, '0);
    add_row(ID_SOC, 64'h0000_0000_0000_FFFF, 1, 1, SIG_SOC, 65535, '0, '0);
    // Pack voltage is divided by 100 and truncated; 99 comes out as zero.
    add_row(ID_PACK, 64'h0000_FFFF_0000_FFFF, 1, 2, SIG_PACK_VOLT, 655, SIG_PACK_TEMP, 65535);
    add_row(ID_PACK, 64'h0000_1234_0000_0063, 1, 2, SIG_PACK_VOLT, 0, SIG_PACK_TEMP, 4660);
    add_row(ID_MINV, 64'hFFFF_FFFF_FFFF_0000, 1, 1, SIG_MIN_VOLT, 0, '0, '0);
    add_row(ID_MINV, 64'h0000_0000_0000_FFFF, 1, 1, SIG_MIN_VOLT, 655, '0, '0);
    // Signed 32-bit words at the most negative, most positive and minus one.
    add_row(ID_CURRENT, 64'h0000_8000_0000_0000, 1, 1, SIG_CURRENT, 32'h8000_0000, '0, '0);
    add_row(ID_POWER, 64'h0000_7FFF_FFFF_0000, 1, 1, SIG_POWER, 32'h7FFF_FFFF, '0, '0);
    add_row(ID_ENERGY, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, SIG_ENERGY, 32'hFFFF_FFFF, '0, '0);
    // Unknown identifiers produce nothing.
    add_row(11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, '0, '0, '0, '0);
    add_row(11'h000, 64'h0000_0000_0000_0000, 1, 0, '0, '0, '0, '0);
    // Odometer: first reading after reset is not accumulated, and the upper
    // nibble of byte7 is ignored. Then a decrease and an equal reading.
    add_row(ID_ODO, 64'hFFFF_FF00_0000_0000, 1, 2, SIG_ODOMETER, 20'hFFFFF, SIG_TRIP_DIST, 0);
    add_row(ID_ODO, 64'hF000_0100_0000_0000, 1, 2, SIG_ODOMETER, 1, SIG_TRIP_DIST, 0);
    add_row(ID_ODO, 64'h0000_01FF_FFFF_FFFF, 1, 2, SIG_ODOMETER, 1, SIG_TRIP_DIST, 0);
    // A forward step, a reset of the reading to zero, and a step from zero.
    add_row(ID_ODO, 64'h0FFF_FF00_0000_0000, 0, 0, '0, '0, '0, '0);
    add_row(ID_ODO, 64'h0000_0000_0000_0000, 0, 0, '0, '0, '0, '0);
    add_row(ID_ODO, 64'h0000_0500_0000_0000, 0, 0, '0, '0, '0, '0);
    // Charge counter: first reading skipped, then a signed jump from the most
    // negative to the most positive saturates the accumulator at once.
    add_row(ID_CHARGE, 64'h0000_8000_0000_0000, 1, 1, SIG_TRIP_CHG, 0, '0, '0);
    add_row(ID_CHARGE, 64'h0000_7FFF_FFFF_0000, 1, 1, SIG_TRIP_CHG, 32'h7FFF_FFFF, '0, '0);
    add_row(ID_CHARGE, 64'h0000_FFFF_FFFF_0000, 0, 0, '0, '0, '0, '0);
    add_row(ID_CHARGE, 64'h0000_0000_0000_0000, 0, 0, '0, '0, '0, '0);
    add_row(ID_POWER, 64'h0000_0000_0000_0000, 0, 0, '0, '0, '0, '0);

    // Reset is applied once, at the start.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) run_row(dir_rows[i]);
    drain();

    // Random frames, in two halves with a full drain in between.
    gen_odo = odo_prev;
    gen_chg = charge_prev;
    r.typed = 0;
    r.n_res = 0;
    r.c0    = '0;
    r.v0    = '0;
    r.c1    = '0;
    r.v1    = '0;
    for (int i = 0; i < RANDOM_FRAMES; i++) begin
      r.frame = make_random_frame();
      run_row(r);
    end
    drain();
    for (int i = 0; i < RANDOM_FRAMES; i++) begin
      r.frame = make_random_frame();
      run_row(r);
    end

    // Odometer sweep: alternating 1 and the top reading adds nearly 2^20 per
    // pair, so the trip distance adder sees wide steps and long carries.
    for (int i = 0; i < SWEEP_FRAMES; i++) begin
      r.frame.id   = ID_ODO;
      r.frame.data = {$urandom, $urandom};
      r.frame.data[7][3:0] = (i % 2 == 0) ? 4'h0 : 4'hF;
      r.frame.data[6]      = (i % 2 == 0) ? 8'h00 : 8'hFF;
      r.frame.data[5]      = (i % 2 == 0) ? 8'h01 : 8'hFF;
      run_row(r);
    end

    // Wait for every owed signal, then a little longer for strays.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d frames (directed table, random mix, odometer step sweep)",
             frames_sent);
    $display("checked %0d signal items, %0d mismatches, %0d left owed", signals_checked,
             mismatches, pending_signals.size());
    if (mismatches == 0 && pending_signals.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/vcsd_pkg.sv
sv/vcsd_fifo.sv
sv/vcsd_front.sv
sv/vcsd_back.sv
sv/vehicle_can_signal_decoder.sv
tb/sv/tb_top.sv
